### hdl/txcon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared field widths, character codes and register indexes of the text
// console engine.
// ----------------------------------------------------------------------------
package txcon_pkg;

    localparam int COMMAND_W    = 1;
    localparam int CHAR_W       = 8;
    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 4;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0]  RESET_ATTR   = 8'h07;
    localparam logic [COLOR_W-1:0] RESET_FORE   = 4'h7;
    localparam logic [COLOR_W-1:0] RESET_BACK   = 4'h0;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FORE_COLOR = 1'b0,
        CFG_BACK_COLOR = 1'b1
    } t_cfg_index;

endpackage

### hdl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell console: a screen memory of ROWS x COLS cells and a cursor.
// ----------------------------------------------------------------------------
// Usage: each input word carries a command. A write command stores a byte at
// the cursor (newline moves the cursor to the start of the next row) and a
// read command fetches one cell. Every word returns one output word with the
// cell (zero for writes and for reads off the screen) and the cursor after it.
// Colors come from the config write port and apply to later writes only.
// Timing: the cell memory is single ported with a registered read. An
// ordinary write or an off-screen read passes S_IDLE and S_DONE into the
// output register, an on-screen read S_IDLE, S_READ and S_DONE. A scroll
// rotates a row offset rather than moving cells, then blanks the new bottom
// row one cell a cycle in S_BLANK. One word is worked on at a time.
// Reset: the cursor goes home, colors go to grey on black, and a clearing
// pass writes a grey-on-black space into every cell, during which o_in_ready
// stays low.
// Stall: the result sits in the output register until i_out_ready; a new
// word may be taken meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
    import txcon_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [COLOR_W-1:0]       i_cfg_wdata,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COMMAND_W-1:0]     i_command,
    input  logic [CHAR_W-1:0]        i_char_code,
    input  logic [ROW_FIELD_W-1:0]   i_read_row,
    input  logic [COL_FIELD_W-1:0]   i_read_col,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CELL_W-1:0]        o_cell_entry,
    output logic [ROW_FIELD_W-1:0]   o_cursor_row,
    output logic [COL_FIELD_W-1:0]   o_cursor_col
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_BLANK,
        S_DONE
    } t_state;

    // cell memory, row address is the physical row
    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;

    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_top, n_top;
    logic [RW-1:0]     r_sw_row, n_sw_row;
    logic [CW-1:0]     r_sw_col, n_sw_col;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic [COLOR_W-1:0] r_fore, r_back;
    logic              r_out_valid, n_out_valid;
    logic [CELL_W-1:0] r_out_cell, n_out_cell;
    logic [RW-1:0]     r_out_row, n_out_row;
    logic [CW-1:0]     r_out_col, n_out_col;

    logic              accept;
    logic [CHAR_W-1:0] attr;
    logic [RW:0]       wr_sum, rd_sum, top_sum;
    logic [RW-1:0]     wr_phys, rd_phys, top_next;
    logic [RW-1:0]     rd_row;
    logic [CW-1:0]     rd_col;
    logic              rd_in_range;
    logic [CW:0]       col_inc;
    logic              is_newline;
    logic              wrap;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign attr       = {r_back, r_fore};

    // logical row to physical row through the scroll offset
    always_comb begin
        rd_row  = RW'(i_read_row);
        rd_col  = CW'(i_read_col);
        wr_sum  = {1'b0, r_row} + {1'b0, r_top};
        rd_sum  = {1'b0, rd_row} + {1'b0, r_top};
        top_sum = {1'b0, r_top} + (RW+1)'(1);
        wr_phys  = (wr_sum >= (RW+1)'(ROWS)) ? RW'(wr_sum - (RW+1)'(ROWS)) : wr_sum[RW-1:0];
        rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : rd_sum[RW-1:0];
        top_next = (top_sum >= (RW+1)'(ROWS)) ? RW'(top_sum - (RW+1)'(ROWS))
                                              : top_sum[RW-1:0];
        rd_in_range = (int'(i_read_row) < ROWS) && (int'(i_read_col) < COLS);
        col_inc     = {1'b0, r_col} + (CW+1)'(1);
        is_newline  = (i_char_code == NEWLINE_CHAR);
        wrap        = is_newline || (col_inc >= (CW+1)'(COLS));
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_sw_row    = r_sw_row;
        n_sw_col    = r_sw_col;
        n_cell      = r_cell;
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = {r_sw_row, r_sw_col};
        mem_wdata   = {attr, BLANK_CHAR};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                if (r_sw_col == LAST_COL) begin
                    n_sw_col = '0;
                    if (r_sw_row == LAST_ROW) begin
                        n_sw_row = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_sw_row = r_sw_row + RW'(1);
                    end
                end else begin
                    n_sw_col = r_sw_col + CW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    n_cell  = '0;
                    if (t_command'(i_command) == CMD_READ) begin
                        if (rd_in_range) begin
                            mem_re   = 1'b1;
                            mem_addr = {rd_phys, rd_col};
                            n_state  = S_READ;
                        end
                    end else begin
                        mem_we    = !is_newline;
                        mem_addr  = {wr_phys, r_col};
                        mem_wdata = {attr, i_char_code};
                        if (!wrap) begin
                            n_col = col_inc[CW-1:0];
                        end else begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                // old top row becomes the blank bottom row
                                n_top    = top_next;
                                n_sw_row = r_top;
                                n_sw_col = '0;
                                n_state  = S_BLANK;
                            end else begin
                                n_row = r_row + RW'(1);
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_cell  = r_rd_data;
                n_state = S_DONE;
            end
            S_BLANK: begin
                mem_we = 1'b1;
                if (r_sw_col == LAST_COL) begin
                    n_sw_col = '0;
                    n_state  = S_DONE;
                end else begin
                    n_sw_col = r_sw_col + CW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_cell;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_sw_row    <= '0;
            r_sw_col    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_sw_row    <= n_sw_row;
            r_sw_col    <= n_sw_col;
            r_out_valid <= n_out_valid;
        end
        r_cell     <= n_cell;
        r_out_cell <= n_out_cell;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= RESET_FORE;
            r_back <= RESET_BACK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FORE_COLOR: r_fore <= i_cfg_wdata;
                CFG_BACK_COLOR: r_back <= i_cfg_wdata;
                default:        r_fore <= r_fore;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_entry = r_out_cell;
    assign o_cursor_row = ROW_FIELD_W'(r_out_row);
    assign o_cursor_col = COL_FIELD_W'(r_out_col);

endmodule

### verif/text_console_cursor_scroll_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_test
// Self-checking bench for the text console engine. Write and read words go in
// over valid/ready while a shadow screen and cursor predict every output word;
// results are checked in order, with random idling on both channels, color
// changes between phases and text streams that wrap lines and scroll.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_test;
    import txcon_pkg::*;

    localparam int COLS          = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = ROWS * COLS;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = COLS + 4;

    typedef struct packed {
        logic [CELL_W-1:0]      entry;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } t_console_word;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]     i_cfg_wdata = '0;
    logic                   i_in_valid  = 1'b0;
    logic [COMMAND_W-1:0]   i_command   = '0;
    logic [CHAR_W-1:0]      i_char_code = '0;
    logic [ROW_FIELD_W-1:0] i_read_row  = '0;
    logic [COL_FIELD_W-1:0] i_read_col  = '0;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [CELL_W-1:0]      o_cell_entry;
    logic [ROW_FIELD_W-1:0] o_cursor_row;
    logic [COL_FIELD_W-1:0] o_cursor_col;

    // both channels run without idling while this is set
    logic steady = 1'b0;

    int mismatches   = 0;
    int quiet_cycles = 0;

    logic [CELL_W-1:0]  shadow_screen [CELLS];
    int unsigned        shadow_row;
    int unsigned        shadow_col;
    logic [COLOR_W-1:0] shadow_fore;
    logic [COLOR_W-1:0] shadow_back;
    t_console_word      due_readouts [$];

    text_console_cursor_scroll #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cell_entry(o_cell_entry),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic logic [CELL_W-1:0] colored(input logic [CHAR_W-1:0] ch);
        return {shadow_back, shadow_fore, ch};
    endfunction

    function automatic void line_feed();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
            // past the last row: everything moves up, bottom row blanked in current colors
            for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = colored(BLANK_CHAR);
            shadow_row = ROWS - 1;
        end
    endfunction

    function automatic t_console_word step_console(input t_command cmd,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ROW_FIELD_W-1:0] rr,
                                                   input logic [COL_FIELD_W-1:0] rc);
        t_console_word res;
        res.entry = '0;
        if (cmd == CMD_WRITE) begin
            if (ch == NEWLINE_CHAR) begin
                line_feed();
            end else begin
                shadow_screen[shadow_row * COLS + shadow_col] = colored(ch);
                shadow_col++;
                if (shadow_col >= COLS) line_feed();
            end
        end else if (rr < ROWS && rc < COLS) begin
            res.entry = shadow_screen[rr * COLS + rc];
        end
        res.row = ROW_FIELD_W'(shadow_row);
        res.col = COL_FIELD_W'(shadow_col);
        return res;
    endfunction

    // ---------------- checking ----------------

    function automatic void flag_mismatch(input string what, input t_console_word want,
                                          input t_console_word seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
                     $time, what, want.entry, want.row, want.col,
                     seen.entry, seen.row, seen.col);
    endfunction

    always @(posedge i_clk) begin
        t_console_word seen;
        t_console_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_cell_entry, o_cursor_row, o_cursor_col};
            if (due_readouts.size() == 0) begin
                flag_mismatch("word with nothing pending", '0, seen);
            end else begin
                want = due_readouts.pop_front();
                if (want.entry !== seen.entry || want.row !== seen.row ||
                    want.col !== seen.col)
                    flag_mismatch("wrong word", want, seen);
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // ---------------- driving ----------------

    task automatic send_word(input t_command cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_FIELD_W-1:0] rr,
                             input logic [COL_FIELD_W-1:0] rc);
        if (!steady) begin
            while ($urandom_range(0, 99) < 25) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do @(posedge i_clk); while (!o_in_ready);
        due_readouts.push_back(step_console(cmd, ch, rr, rc));
    endtask

    // drop valid, wait for every pending word, a scroll included, then idle before returning
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_readouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FORE_COLOR) shadow_fore = value;
        else shadow_back = value;
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back);
        drain_and_settle();
        write_register(CFG_FORE_COLOR, fore);
        write_register(CFG_BACK_COLOR, back);
    endtask

    task automatic send_random_word(input int newline_pct, input int read_pct);
        logic [CHAR_W-1:0]      ch;
        logic [ROW_FIELD_W-1:0] rr;
        logic [COL_FIELD_W-1:0] rc;
        ch = CHAR_W'($urandom_range(0, 255));
        rr = ROW_FIELD_W'($urandom_range(0, 31));
        rc = COL_FIELD_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < read_pct) begin
            if ($urandom_range(0, 9) != 0) begin
                // mostly on screen, often the cursor row where text just landed
                rr = ($urandom_range(0, 2) == 0) ? ROW_FIELD_W'(shadow_row)
                                                 : ROW_FIELD_W'($urandom_range(0, ROWS - 1));
                rc = COL_FIELD_W'($urandom_range(0, COLS - 1));
            end
            send_word(CMD_READ, ch, rr, rc);
        end else begin
            if ($urandom_range(0, 99) < newline_pct) ch = NEWLINE_CHAR;
            send_word(CMD_WRITE, ch, rr, rc);
        end
    endtask

    task automatic run_text(input int count, input int newline_pct, input int read_pct);
        for (int n = 0; n < count; n++) send_random_word(newline_pct, read_pct);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_reads();
        send_word(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_word(CMD_READ, 8'hFF, ROW_FIELD_W'(ROWS - 1), COL_FIELD_W'(COLS - 1));
        // off-screen reads return an empty cell
        send_word(CMD_READ, 8'h00, ROW_FIELD_W'(ROWS), 7'd0);
        send_word(CMD_READ, 8'h00, 5'd0, COL_FIELD_W'(COLS));
        send_word(CMD_READ, 8'hFF, 5'd31, 7'd127);
    endtask

    task automatic test_write_bytes();
        send_word(CMD_WRITE, 8'h00, 5'd31, 7'd127);
        send_word(CMD_WRITE, 8'hFF, 5'd0, 7'd0);
        send_word(CMD_WRITE, 8'h80, 5'd0, 7'd0);
        send_word(CMD_WRITE, 8'h41, 5'd0, 7'd0);
        send_word(CMD_WRITE, NEWLINE_CHAR, 5'd0, 7'd0);
        for (int c = 0; c < 5; c++) send_word(CMD_READ, 8'h00, 5'd0, COL_FIELD_W'(c));
    endtask

    task automatic test_color_registers();
        set_colors(4'hF, 4'hF);
        send_word(CMD_WRITE, 8'h5A, 5'd0, 7'd0);
        set_colors(4'h0, 4'h0);
        send_word(CMD_WRITE, BLANK_CHAR, 5'd0, 7'd0);
        send_word(CMD_READ, 8'h00, 5'd1, 7'd0);
        send_word(CMD_READ, 8'h00, 5'd1, 7'd1);
    endtask

    task automatic test_text_streams();
        int newline_mix [4] = '{8, 40, 3, 12};
        set_colors(RESET_FORE, RESET_BACK);
        steady = 1'b1;
        run_text(300, 8, 30);
        steady = 1'b0;
        set_colors(4'h0, 4'hF);
        run_text(240, 20, 30);
        // long unbroken lines wrap at the right edge
        set_colors(4'hF, 4'h0);
        run_text(240, 1, 20);
        for (int p = 0; p < 4; p++) begin
            set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
            run_text(240, newline_mix[p], 30);
        end
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {RESET_ATTR, BLANK_CHAR};
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_fore = RESET_FORE;
        shadow_back = RESET_BACK;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_reads();
        test_write_bytes();
        test_color_registers();
        test_text_streams();

        drain_and_settle();
        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
